@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define SKF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked implication, masked while reset is asserted.
`define SKF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/skf_pkg.sv @@
// Types and constants for the scalar Kalman filter.
// No dependencies.
`timescale 1ns / 1ps

package skf_pkg;

    localparam int COV_W  = 31;
    localparam int EST_W  = 32;
    localparam int GAIN_W = 17;
    localparam int CNT_W  = 5;

    localparam logic [COV_W-1:0]  COV_MAX = {COV_W{1'b1}};
    localparam logic [GAIN_W-1:0] Q_ONE   = 17'h10000;

    // Reset values of the registers and state
    localparam logic [COV_W-1:0] RST_PROC_NOISE = 31'd655;
    localparam logic [COV_W-1:0] RST_MEAS_NOISE = 31'd65536;
    localparam logic [EST_W-1:0] RST_INIT_EST   = 32'd0;
    localparam logic [COV_W-1:0] RST_INIT_COV   = 31'd65536;

    // Register indexes
    localparam logic [1:0] REG_PROC_NOISE = 2'd0;
    localparam logic [1:0] REG_MEAS_NOISE = 2'd1;
    localparam logic [1:0] REG_INIT_EST   = 2'd2;
    localparam logic [1:0] REG_INIT_COV   = 2'd3;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDQ,
        S_ADDR,
        S_DIV,
        S_MULX,
        S_UPDX,
        S_MULP,
        S_UPDP,
        S_OUT
    } fsm_t;

endpackage

@@ rtl/scalar_kalman_filter_top.sv @@
// Scalar Kalman filter, Q16.16 fixed point, one measurement per request.
// Depends on skf_pkg and assert_macros.svh.
//
// Usage:
//   - Input channel s_*: one measurement request (signed Q16.16) per handshake.
//   - Result channel m_*: estimate, gain, covariance and status per request.
//   - cfg_*: write-only register port, index 0 process noise, 1 measurement
//     noise, 2 initial estimate, 3 initial covariance. Write only while idle.
//     Initial estimate/covariance writes are ignored; reset loads fixed defaults.
//   - Steps from accept to m_valid for a full update: ADDQ, ADDR, the 17-step
//     restoring divider for the gain, MULX/UPDX and MULP/UPDP on one 18x34
//     multiplier used twice in turn, then OUT. Early stops reach OUT from ADDQ
//     (covariance overflow), ADDR (divide by zero) or UPDX (estimate overflow).
//   - A new request is taken only once the last one has left the sequencer;
//     s_ready is high only while the sequencer is idle.
//   - The result sits in an output register; a new request is accepted and
//     processed while it waits. The sequencer holds in its last step while a
//     result is still pending, so nothing is overwritten on a stall.
//   - Reset (aresetn low, synchronous) restores the registers to defaults,
//     loads estimate and covariance from those defaults and clears the gain.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scalar_kalman_filter_top
    import skf_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // config port
    input  logic                     cfg_wr_en,
    input  logic [1:0]               cfg_addr,
    input  logic [EST_W-1:0]         cfg_wdata,
    // measurement requests
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [EST_W-1:0]  s_measurement,
    // results
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [EST_W-1:0]  m_estimate_out,
    output logic [GAIN_W-1:0]        m_gain_out,
    output logic [COV_W-1:0]         m_covariance_out,
    output logic [1:0]               m_status
);

    // Config registers
    logic [COV_W-1:0] proc_noise_reg;
    logic [COV_W-1:0] meas_noise_reg;

    // Filter state
    logic signed [EST_W-1:0] est_reg, est_next;
    logic [COV_W-1:0]        cov_reg, cov_next;
    logic [GAIN_W-1:0]       gain_reg, gain_next;

    // Sequencer and datapath
    fsm_t                    state_reg, state_next;
    logic signed [EST_W-1:0] z_reg, z_next;
    logic [EST_W-1:0]        den_reg, den_next;
    logic [EST_W-1:0]        rem_reg, rem_next;
    logic [GAIN_W-1:0]       quo_reg, quo_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [GAIN_W-1:0]       op_a_reg, op_a_next;
    logic signed [33:0]      op_b_reg, op_b_next;
    logic signed [51:0]      prod_reg, prod_next;
    status_t                 stat_reg, stat_next;

    // Output register
    logic                    m_valid_reg, m_valid_next;
    logic signed [EST_W-1:0] m_est_reg, m_est_next;
    logic [GAIN_W-1:0]       m_gain_reg, m_gain_next;
    logic [COV_W-1:0]        m_cov_reg, m_cov_next;
    status_t                 m_stat_reg, m_stat_next;

    // Combinational helpers
    logic [EST_W-1:0]        p1;
    logic [EST_W-1:0]        den_sum;
    logic [EST_W:0]          rem_sh;
    logic [EST_W:0]          rem_sub;
    logic                    qbit;
    logic [GAIN_W-1:0]       quo_new;
    logic signed [32:0]      diff;
    logic signed [35:0]      delta;
    logic signed [36:0]      x1;
    logic                    x1_ovf;

    // Shared multiplier: gain*diff, then (1-gain)*covariance
    assign prod_next = $signed({1'b0, op_a_reg}) * op_b_reg;

    always_comb begin
        p1      = {1'b0, cov_reg} + {1'b0, proc_noise_reg};
        den_sum = {1'b0, cov_reg} + {1'b0, meas_noise_reg};
        // restoring division step; next numerator bit is cov[0] once, then zeros
        rem_sh  = {rem_reg, ((cnt_reg == CNT_W'(16)) ? cov_reg[0] : 1'b0)};
        rem_sub = rem_sh - {1'b0, den_reg};
        qbit    = (rem_sh >= {1'b0, den_reg});
        quo_new = {quo_reg[GAIN_W-2:0], qbit};
        diff    = {z_reg[EST_W-1], z_reg} - {est_reg[EST_W-1], est_reg};
        delta   = prod_reg[51:16];
        x1      = {{5{est_reg[EST_W-1]}}, est_reg} + {delta[35], delta};
        x1_ovf  = (x1[36:31] != {6{x1[31]}});
    end

    always_comb begin
        state_next   = state_reg;
        est_next     = est_reg;
        cov_next     = cov_reg;
        gain_next    = gain_reg;
        z_next       = z_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        op_a_next    = op_a_reg;
        op_b_next    = op_b_reg;
        stat_next    = stat_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_est_next   = m_est_reg;
        m_gain_next  = m_gain_reg;
        m_cov_next   = m_cov_reg;
        m_stat_next  = m_stat_reg;
        s_ready      = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    z_next     = s_measurement;
                    state_next = S_ADDQ;
                end
            end
            S_ADDQ: begin
                if (p1[EST_W-1]) begin
                    cov_next   = COV_MAX;
                    stat_next  = ST_OVF;
                    state_next = S_OUT;
                end else begin
                    cov_next   = p1[COV_W-1:0];
                    state_next = S_ADDR;
                end
            end
            S_ADDR: begin
                if (den_sum == '0) begin
                    stat_next  = ST_DIV0;
                    state_next = S_OUT;
                end else begin
                    den_next   = den_sum;
                    rem_next   = {2'b0, cov_reg[COV_W-1:1]};
                    quo_next   = '0;
                    cnt_next   = CNT_W'(16);
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                rem_next = qbit ? rem_sub[EST_W-1:0] : rem_sh[EST_W-1:0];
                quo_next = quo_new;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    gain_next  = quo_new;
                    op_a_next  = quo_new;
                    op_b_next  = {diff[32], diff};
                    state_next = S_MULX;
                end
            end
            S_MULX: begin
                state_next = S_UPDX;
            end
            S_UPDX: begin
                if (x1_ovf) begin
                    est_next   = x1[36] ? {1'b1, {(EST_W-1){1'b0}}} : {1'b0, {(EST_W-1){1'b1}}};
                    stat_next  = ST_OVF;
                    state_next = S_OUT;
                end else begin
                    est_next   = x1[EST_W-1:0];
                    op_a_next  = Q_ONE - gain_reg;
                    op_b_next  = {3'b0, cov_reg};
                    state_next = S_MULP;
                end
            end
            S_MULP: begin
                state_next = S_UPDP;
            end
            S_UPDP: begin
                // (1-K)*P never grows P; clamp kept as a guard
                if (prod_reg[51:47] != '0) begin
                    cov_next  = COV_MAX;
                    stat_next = ST_OVF;
                end else begin
                    cov_next  = prod_reg[46:16];
                    stat_next = ST_OK;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_est_next   = est_reg;
                    m_gain_next  = gain_reg;
                    m_cov_next   = cov_reg;
                    m_stat_next  = stat_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, filter state and config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            proc_noise_reg <= RST_PROC_NOISE;
            meas_noise_reg <= RST_MEAS_NOISE;
            est_reg        <= RST_INIT_EST;
            cov_reg        <= RST_INIT_COV;
            gain_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            est_reg     <= est_next;
            cov_reg     <= cov_next;
            gain_reg    <= gain_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_PROC_NOISE: proc_noise_reg <= cfg_wdata[COV_W-1:0];
                    REG_MEAS_NOISE: meas_noise_reg <= cfg_wdata[COV_W-1:0];
                    // initial estimate/covariance writes are ignored; reset loads fixed defaults
                    REG_INIT_EST, REG_INIT_COV: ;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        z_reg      <= z_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        op_a_reg   <= op_a_next;
        op_b_reg   <= op_b_next;
        prod_reg   <= prod_next;
        stat_reg   <= stat_next;
        m_est_reg  <= m_est_next;
        m_gain_reg <= m_gain_next;
        m_cov_reg  <= m_cov_next;
        m_stat_reg <= m_stat_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_estimate_out   = m_est_reg;
    assign m_gain_out       = m_gain_reg;
    assign m_covariance_out = m_cov_reg;
    assign m_status         = m_stat_reg;

    // Checks
    `SKF_ASSERT(a_gain_range, gain_reg <= Q_ONE, "gain above one")
    `SKF_ASSERT_IMP(a_div_rem, state_reg == S_DIV, rem_reg < den_reg, "divider remainder too big")
    `SKF_ASSERT_IMP(a_busy_after_accept, s_valid && s_ready, ##1 !s_ready, "request taken while busy")
    `SKF_ASSERT_IMP(a_div0_cov, m_valid && m_status == ST_DIV0, m_covariance_out == '0,
        "divide by zero with nonzero covariance")

endmodule
